[hw/rtl/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg: shared codes for the rational arithmetic core
// Operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package rar_pkg;
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;
endpackage
`default_nettype wire

[hw/rtl/rational_arith_reduce_core.sv]
// ----------------------------------------------------------------------------
// rational_arith_reduce_core: add/sub/mul/div of two fractions, gcd reduced
// Iterative datapath: one shared wide adder/subtractor under a sequencer.
// ----------------------------------------------------------------------------
// Sequence: shift-add multiplies form the cross products (two for mul/div,
// three for add/sub), then a binary gcd with the shift back and two
// restoring divisions by the gcd. Flagged inputs and zero results go
// straight to the output. One item at a time; the next is taken once
// the result has left the output register. Reset clears the sequencer and
// the output valid; no other state.
`default_nettype none
module rational_arith_reduce_core #(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic signed [31:0] a_num,
	input  wire logic signed [31:0] a_den,
	input  wire logic signed [31:0] b_num,
	input  wire logic signed [31:0] b_den,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] res_num,
	output logic [30:0]      res_den,
	output logic [1:0]       status
);
	localparam int W  = OPERAND_WIDTH;
	localparam int DW = 2 * W + 1;              // room for sum of products
	localparam int CW = $clog2(DW + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
		S_M4 = 4'd4, S_SUM = 4'd5, S_G = 4'd6, S_GF = 4'd7, S_D1 = 4'd8,
		S_D2 = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;

	logic [3:0] state_q;
	logic [1:0] op_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic an_n_q, ad_n_q, bn_n_q, bd_n_q;
	logic [DW-1:0] acc_q, mc_q, p1_q, den_q, x_q, y_q, q_q, r_q;
	logic [W-1:0] mp_q;
	logic [CW-1:0] cnt_q, sh_q;
	logic n1_q, n2_q, nneg_q;

	function automatic logic [W-1:0] mag_of(input logic [31:0] v, output logic ng);
		logic [W-1:0] t;
		t = v[W-1:0];
		ng = t[W-1];
		mag_of = ng ? (~t + 1'b1) : t;
	endfunction

	logic [W-1:0] an_m, ad_m, bn_m, bd_m;
	logic an_s, ad_s, bn_s, bd_s;
	always_comb begin
		an_m = mag_of(a_num, an_s);
		ad_m = mag_of(a_den, ad_s);
		bn_m = mag_of(b_num, bn_s);
		bd_m = mag_of(b_den, bd_s);
	end

	// shared adder/subtractor
	logic [DW-1:0] alu_a, alu_b, alu_y;
	logic alu_sub;
	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	logic [DW-1:0] rsh;
	assign rsh = {r_q[DW-2:0], q_q[DW-1]};

	always_comb begin
		alu_a = acc_q; alu_b = mc_q; alu_sub = 1'b0;
		unique case (state_q)
			S_G: begin
				alu_a = (x_q > y_q) ? x_q : y_q;
				alu_b = (x_q > y_q) ? y_q : x_q;
				alu_sub = 1'b1;
			end
			S_D1, S_D2: begin alu_a = rsh; alu_b = p1_q; alu_sub = 1'b1; end
			S_SUM: begin
				alu_a = (p1_q >= acc_q || n1_q == n2_q) ? p1_q : acc_q;
				alu_b = (p1_q >= acc_q || n1_q == n2_q) ? acc_q : p1_q;
				alu_sub = (n1_q != n2_q);
			end
			default: ;
		endcase
	end

	logic ovf;
	always_comb begin
		ovf = (den_q > DW'((64'd1 << (W - 1)) - 1)) ||
			(acc_q > DW'((64'd1 << (W - 1)) - (nneg_q ? 0 : 1)));
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= operation;
					an_q <= an_m; ad_q <= ad_m; bn_q <= bn_m; bd_q <= bd_m;
					an_n_q <= an_s; ad_n_q <= ad_s; bn_n_q <= bn_s; bd_n_q <= bd_s;
					if (ad_m == '0 || bd_m == '0 ||
						(operation == rar_pkg::OP_DIV && bn_m == '0)) begin
						res_num <= '0; res_den <= '0; status <= rar_pkg::ST_ZERO;
						out_valid <= 1'b1; state_q <= S_OUT;
					end else begin
						// first product: an*bd (add/sub/div) or an*bn (mul)
						acc_q <= '0; cnt_q <= '0;
						mc_q <= DW'(an_m);
						mp_q <= (operation == rar_pkg::OP_MUL) ? bn_m : bd_m;
						state_q <= S_M1;
					end
				end
				S_M1, S_M2, S_M3: begin
					if (mp_q[0]) acc_q <= alu_y;
					mc_q <= {mc_q[DW-2:0], 1'b0};
					mp_q <= mp_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W - 1)) begin
						cnt_q <= '0;
						acc_q <= '0;
						p1_q <= mp_q[0] ? alu_y : acc_q;
						if (state_q == S_M1) begin
							n1_q <= an_n_q ^ ((op_q == rar_pkg::OP_MUL) ? bn_n_q : bd_n_q);
							mc_q <= DW'(ad_q);
							mp_q <= (op_q == rar_pkg::OP_DIV) ? bn_q : bd_q;
							den_q <= (mp_q[0] ? alu_y : acc_q);
							state_q <= S_M2;
						end else if (state_q == S_M2) begin
							// den_q takes den; first product moves to p1
							den_q <= mp_q[0] ? alu_y : acc_q;
							p1_q <= den_q;
							nneg_q <= ad_n_q ^ ((op_q == rar_pkg::OP_DIV) ? bn_n_q : bd_n_q);
							if (op_q == rar_pkg::OP_ADD || op_q == rar_pkg::OP_SUB) begin
								mc_q <= DW'(bn_q); mp_q <= ad_q;
								state_q <= S_M3;
							end else begin
								acc_q <= den_q; n2_q <= 1'b0;
								state_q <= S_M4;
							end
						end else begin
							acc_q <= mp_q[0] ? alu_y : acc_q;
							p1_q <= den_q;           // save den
							den_q <= p1_q;           // first product
							n2_q <= bn_n_q ^ ad_n_q ^ (op_q == rar_pkg::OP_SUB);
							state_q <= S_M4;
						end
					end
				end
				S_M4: begin
					// align: p1 = first product (num for mul/div), acc = second (zero for mul/div), den_q = den
					if (op_q == rar_pkg::OP_ADD || op_q == rar_pkg::OP_SUB) begin
						den_q <= p1_q; p1_q <= den_q;
						state_q <= S_SUM;
					end else begin
						acc_q <= '0; p1_q <= acc_q; state_q <= S_SUM;
					end
				end
				S_SUM: begin
					acc_q <= alu_y;
					if (n1_q == n2_q || p1_q >= acc_q) n1_q <= n1_q;
					else n1_q <= n2_q;
					x_q <= alu_y; y_q <= den_q; sh_q <= '0;
					if (alu_y == '0) begin
						res_num <= '0; res_den <= 31'd1; status <= rar_pkg::ST_OK;
						out_valid <= 1'b1; state_q <= S_OUT;
					end else begin
						state_q <= S_G;
					end
				end
				S_G: begin
					// binary gcd
					if (x_q == y_q) state_q <= S_GF;
					else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1; y_q <= y_q >> 1; sh_q <= sh_q + 1'b1;
					end else if (!x_q[0]) x_q <= x_q >> 1;
					else if (!y_q[0]) y_q <= y_q >> 1;
					else if (x_q > y_q) x_q <= alu_y >> 1;
					else y_q <= alu_y >> 1;
				end
				S_GF: begin
					if (sh_q != '0) begin
						x_q <= {x_q[DW-2:0], 1'b0}; sh_q <= sh_q - 1'b1;
					end else begin
						p1_q <= x_q; q_q <= acc_q; r_q <= '0; cnt_q <= '0;
						state_q <= S_D1;
					end
				end
				S_D1, S_D2: begin
					if (alu_y[DW-1]) begin
						r_q <= rsh; q_q <= {q_q[DW-2:0], 1'b0};
					end else begin
						r_q <= alu_y; q_q <= {q_q[DW-2:0], 1'b1};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DW - 1)) begin
						cnt_q <= '0;
						if (state_q == S_D1) begin
							acc_q <= {q_q[DW-2:0], ~alu_y[DW-1]};
							q_q <= den_q; r_q <= '0; state_q <= S_D2;
						end else begin
							den_q <= {q_q[DW-2:0], ~alu_y[DW-1]};
							nneg_q <= n1_q ^ nneg_q;
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (ovf) begin
						res_num <= '0; res_den <= '0; status <= rar_pkg::ST_OVF;
					end else begin
						res_num <= 32'(signed'(nneg_q ? (~acc_q[W-1:0] + 1'b1) : acc_q[W-1:0]));
						res_den <= 31'(den_q[W-2:0]);
						status <= rar_pkg::ST_OK;
					end
					out_valid <= 1'b1; state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for rational_arith_reduce_core
// A directed table of edge cases is driven first, then random fraction pairs.
// Results are checked against fixed rows or a predictor that reduces exact
// cross products by gcd; both channels idle at random save in the last third.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] an, ad, bn, bd;
		logic               fixed;
		logic signed [31:0] xnum;
		logic [30:0]        xden;
		logic [1:0]         xst;
	} vec_t;

	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic [1:0]         st;
	} frac_t;

	localparam int N_RANDOM = 1430;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = rar_pkg::OP_ADD;
	logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic [1:0] status;

	int send_idle_pct = 28;
	int recv_idle_pct = 69;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_ovf = 0;
	int n_zero = 0;
	frac_t pending_q[$];
	vec_t dir_tab[$];

	always #4 clk = ~clk;

	rational_arith_reduce_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .a_num(a_num), .a_den(a_den),
		.b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .status(status)
	);

	function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// exact rational result; magnitudes fit 64 bits, sums computed in 67 bits
	function automatic frac_t reduce_frac(logic [1:0] op, logic signed [31:0] an,
			logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
		frac_t r;
		logic signed [66:0] num, den, g;
		logic [63:0] nm, dm;
		logic neg;
		r = '{num: '0, den: '0, st: rar_pkg::ST_OK};
		if (ad == 0 || bd == 0 || (op == rar_pkg::OP_DIV && bn == 0)) begin
			r.st = rar_pkg::ST_ZERO;
			return r;
		end
		case (op)
			rar_pkg::OP_ADD: begin
				num = 67'(an) * 67'(bd) + 67'(bn) * 67'(ad);
				den = 67'(ad) * 67'(bd);
			end
			rar_pkg::OP_SUB: begin
				num = 67'(an) * 67'(bd) - 67'(bn) * 67'(ad);
				den = 67'(ad) * 67'(bd);
			end
			rar_pkg::OP_MUL: begin
				num = 67'(an) * 67'(bn);
				den = 67'(ad) * 67'(bd);
			end
			default: begin
				num = 67'(an) * 67'(bd);
				den = 67'(ad) * 67'(bn);
			end
		endcase
		if (num == 0) begin
			r.den = 31'd1;
			return r;
		end
		neg = (num < 0) != (den < 0);
		nm = 64'(num < 0 ? -num : num);
		dm = 64'(den < 0 ? -den : den);
		g = 67'(gcd_of(nm, dm));
		nm = nm / 64'(g);
		dm = dm / 64'(g);
		if (nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF) || dm > 64'h7FFF_FFFF) begin
			r.st = rar_pkg::ST_OVF;
			return r;
		end
		r.num = neg ? 32'(-nm) : 32'(nm);
		r.den = 31'(dm);
		return r;
	endfunction

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'(signed'($urandom_range(0, 20)) - 10);
			1: return 32'(signed'($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? S_MIN : S_MAX;
			3: return 32'($urandom_range(0, 1) ? 1 : -1) << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	// valid stays high into the next transaction unless the sender idles
	task automatic send(vec_t v);
		frac_t exp_r;
		exp_r = reduce_frac(v.op, v.an, v.ad, v.bn, v.bd);
		if (v.fixed && (exp_r.num !== v.xnum || exp_r.den !== v.xden || exp_r.st !== v.xst))
			$display("%0t table row disagrees with predictor (op %0d)", $time, v.op);
		if (v.fixed)
			exp_r = '{num: v.xnum, den: v.xden, st: v.xst};
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pending_q.push_back(exp_r);
		operation <= v.op;
		a_num <= v.an;
		a_den <= v.ad;
		b_num <= v.bn;
		b_den <= v.bd;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	// result check and receiver idling
	always @(posedge clk) begin
		frac_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result %0d/%0d st %0d", $time,
					res_num, res_den, status);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (res_num !== e.num) begin
					$display("%0t res_num exp %0d got %0d", $time, e.num, res_num);
					errors++;
				end
				if (res_den !== e.den) begin
					$display("%0t res_den exp %0d got %0d", $time, e.den, res_den);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t status exp %0d got %0d", $time, e.st, status);
					errors++;
				end
				if (e.st == rar_pkg::ST_OVF) n_ovf++;
				if (e.st == rar_pkg::ST_ZERO) n_zero++;
				n_checked++;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		vec_t v;
		int k;
		// op, an, ad, bn, bd, fixed, expected num, den, status
		dir_tab = '{
			'{rar_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6, rar_pkg::ST_OK},
			'{rar_pkg::OP_SUB, 1, 2, 1, 2, 1, 0, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_MUL, 2, -4, 3, 9, 1, -1, 6, rar_pkg::ST_OK},
			'{rar_pkg::OP_DIV, 1, 2, 0, 5, 1, 0, 0, rar_pkg::ST_ZERO},
			'{rar_pkg::OP_ADD, 1, 0, 1, 1, 1, 0, 0, rar_pkg::ST_ZERO},
			'{rar_pkg::OP_MUL, 1, 1, 1, 0, 1, 0, 0, rar_pkg::ST_ZERO},
			'{rar_pkg::OP_DIV, 3, 4, 3, 4, 1, 1, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_MUL, S_MIN, 1, 1, 1, 1, S_MIN, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_MUL, S_MIN, 1, -1, 1, 1, 0, 0, rar_pkg::ST_OVF},
			'{rar_pkg::OP_DIV, 1, S_MIN, 1, 1, 1, 0, 0, rar_pkg::ST_OVF},
			'{rar_pkg::OP_DIV, 1, -1, 1, S_MIN, 1, 0, 0, rar_pkg::ST_OVF},
			'{rar_pkg::OP_ADD, S_MAX, 1, S_MAX, 1, 1, 0, 0, rar_pkg::ST_OVF},
			'{rar_pkg::OP_SUB, S_MIN, 1, S_MIN, 1, 1, 0, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_MUL, S_MAX, S_MAX, S_MAX, S_MAX, 1, 1, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_DIV, S_MIN, S_MIN, S_MIN, S_MIN, 1, 1, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_ADD, 0, -7, 0, 5, 1, 0, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_SUB, -1, -1, -1, -1, 1, 0, 1, rar_pkg::ST_OK},
			'{rar_pkg::OP_MUL, 1, S_MAX, 1, S_MAX, 1, 0, 0, rar_pkg::ST_OVF},
			'{rar_pkg::OP_ADD, 1, S_MAX, 1, S_MIN, 0, 0, 0, rar_pkg::ST_OK},
			'{rar_pkg::OP_SUB, S_MAX, S_MIN, S_MIN, S_MAX, 0, 0, 0, rar_pkg::ST_OK},
			'{rar_pkg::OP_DIV, 32'hFFFF, 32'h10000, -32'h7, 32'h3, 0, 0, 0, rar_pkg::ST_OK}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send(dir_tab[i]);
		for (k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 3) begin
				send_idle_pct = 69;
				recv_idle_pct = 28;
			end else if (k == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			v.op = 2'($urandom_range(0, 3));
			v.an = rand_val();
			v.ad = rand_val();
			v.bn = rand_val();
			v.bd = rand_val();
			if ($urandom_range(0, 9) != 0) begin
				// mostly nonzero denominators so the datapath is exercised
				if (v.ad == 0) v.ad = 1;
				if (v.bd == 0) v.bd = -1;
			end
			v.fixed = 1'b0;
			send(v);
		end
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		$display("Sent %0d transactions, checked %0d results", n_sent, n_checked);
		$display("Error statuses: %0d zero-denominator, %0d overflow", n_zero, n_ovf);
		if (errors == 0 && pending_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/rar_pkg.sv
hw/rtl/rational_arith_reduce_core.sv
tb/tb.sv
